FILE: src/perspective_barycentric_weights_defines.svh
// ---------------------------------------------------------------------------
// Perspective barycentric weights: assertion macros
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef PERSPECTIVE_BARYCENTRIC_WEIGHTS_DEFINES_SVH
`define PERSPECTIVE_BARYCENTRIC_WEIGHTS_DEFINES_SVH

// same-cycle implication
`define PBW_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication with a fixed delay in cycles
`define PBW_ASSERT_LAT(label, ante, n, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(n) (cons)) \
    else $error(msg);

`endif

FILE: src/pbw_pkg.sv
// ---------------------------------------------------------------------------
// pbw_pkg
// Widths, limits, register indexes and control bundles of the weight pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package pbw_pkg;

  // fixed field widths
  localparam int XY_W       = 48;
  localparam int W_W        = 32;
  localparam int TAG_W      = 16;
  localparam int OUT_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  // screen geometry, Q.8
  localparam int COORD_W  = 24;
  localparam int PIX_FRAC = 8;
  localparam int DIF_W    = 25;
  localparam int PROD_W   = 50;
  localparam int CRS_W    = 51;
  localparam int N_W      = 53;
  localparam int DEN1_W   = 51;

  // screen weight division: 32 fraction bits, 60 quotient bits
  localparam int SCR_FRAC  = 32;
  localparam int SCR_SHIFT = 28;
  localparam int DIV1_K    = 60;
  localparam int SAT1_W    = DEN1_W + SCR_SHIFT;

  // perspective division by w: 16 fraction bits, 60 quotient bits
  localparam int W_FRAC      = 16;
  localparam int W_SAT_SHIFT = 44;
  localparam int DIV2_K      = 60;
  localparam int SAT2_W      = W_W + W_SAT_SHIFT;

  // perspective terms and their sum
  localparam int Q_W    = 60;
  localparam int Q_SW   = 61;
  localparam int SUM_W  = 63;
  localparam int DEN3_W = 62;
  localparam int DIV3_K = 32;

  localparam logic [Q_W-1:0]   Q_LIM   = '1;
  localparam logic [OUT_W-1:0] LIM_POS = 32'h7FFF_FFFF;
  localparam logic [OUT_W-1:0] LIM_NEG = 32'h8000_0000;
  localparam logic [W_W-1:0]   W_RESET = 32'h0001_0000;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_A_XY = 3'd0,
    REG_B_XY = 3'd1,
    REG_C_XY = 3'd2,
    REG_A_W  = 3'd3,
    REG_B_W  = 3'd4,
    REG_C_W  = 3'd5
  } cfg_reg_t;

  // per-word control carried alongside the dividers
  typedef struct packed {
    logic             deg;
    logic [TAG_W-1:0] tag;
  } item_ctl_t;

  // per-lane sign and saturation of one division
  typedef struct packed {
    logic neg;
    logic sat;
  } lane_ctl_t;

  typedef struct packed {
    item_ctl_t item;
    lane_ctl_t lane;
  } div_ctl_t;

endpackage

`default_nettype wire

FILE: src/pbw_div.sv
// ---------------------------------------------------------------------------
// pbw_div
// Pipelined restoring divider, one quotient bit per register stage.
// ---------------------------------------------------------------------------
`default_nettype none

module pbw_div #(
  parameter int DW  = 51,
  parameter int K   = 60,
  parameter int SBW = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic [DW-1:0]  in_rem,
  input  logic [K-1:0]   in_low,
  input  logic [DW-1:0]  in_den,
  input  logic [SBW-1:0] in_side,
  output logic           out_valid,
  output logic [K-1:0]   out_quot,
  output logic [SBW-1:0] out_side
);

  logic           valid_r [K];
  logic [DW-1:0]  rem_r   [K];
  logic [K-1:0]   low_r   [K];
  logic [K-1:0]   quot_r  [K];
  logic [DW-1:0]  den_r   [K];
  logic [SBW-1:0] side_r  [K];

  for (genvar j = 0; j < K; j++) begin : g_step
    logic           v_src;
    logic [DW-1:0]  rem_src;
    logic [K-1:0]   low_src;
    logic [K-1:0]   quot_src;
    logic [DW-1:0]  den_src;
    logic [SBW-1:0] side_src;
    logic [DW:0]    trial;
    logic [DW:0]    diff;
    logic           fits;
    logic [DW-1:0]  rem_nxt;

    // stage source: ports for the first step, previous stage after
    if (j == 0) begin : g_first
      assign v_src    = in_valid;
      assign rem_src  = in_rem;
      assign low_src  = in_low;
      assign quot_src = '0;
      assign den_src  = in_den;
      assign side_src = in_side;
    end else begin : g_next
      assign v_src    = valid_r[j-1];
      assign rem_src  = rem_r[j-1];
      assign low_src  = low_r[j-1];
      assign quot_src = quot_r[j-1];
      assign den_src  = den_r[j-1];
      assign side_src = side_r[j-1];
    end

    // bring down the next dividend bit and try the subtract
    assign trial   = {rem_src, low_src[K-1]};
    assign diff    = trial - {1'b0, den_src};
    assign fits    = (trial >= {1'b0, den_src});
    assign rem_nxt = fits ? diff[DW-1:0] : trial[DW-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[j] <= 1'b0;
      end else begin
        valid_r[j] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[j]  <= rem_nxt;
      low_r[j]  <= {low_src[K-2:0], 1'b0};
      quot_r[j] <= {quot_src[K-2:0], fits};
      den_r[j]  <= den_src;
      side_r[j] <= side_src;
    end
  end

  assign out_valid = valid_r[K-1];
  assign out_quot  = quot_r[K-1];
  assign out_side  = side_r[K-1];

endmodule

`default_nettype wire

FILE: src/perspective_barycentric_weights.sv
// ---------------------------------------------------------------------------
// perspective_barycentric_weights
// Perspective-correct barycentric weights of one triangle, one pixel a clock.
// ---------------------------------------------------------------------------
// Usage
//   Write the three vertex positions (Q16.8 x and y) and clip w values (Q16.16)
//   through cfg_we / cfg_index / cfg_data while no pixel is in flight.
//   A pixel word is taken at each rising edge with start high and busy low;
//   busy is high only during reset and in the first cycle after it, so
//   one word a clock is accepted from then on.
//   Each word gives one result, marked by out_valid for a single cycle.
//   Throughput is one word per clock: every stage, including the three
//   bit-per-stage divider chains (60, 60 and 32 stages), advances each cycle.
//   The receiver cannot hold results off and nothing waits on it.
//   Reset clears the pipeline valid bits and loads the registers with
//   all positions zero and all w equal to one.
//   A zero determinant, zero w or zero weight sum raises out_degenerate
//   with zero weights.
// ---------------------------------------------------------------------------
`default_nettype none

`include "perspective_barycentric_weights_defines.svh"

module perspective_barycentric_weights #(
  parameter int WEIGHT_FRAC_BITS = 28,
  parameter int PIXEL_COORD_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [15:0]                     in_pixel_x,
  input  logic signed [15:0]                     in_pixel_y,
  input  logic [pbw_pkg::TAG_W-1:0]              in_instance_tag,
  output logic                                   out_valid,
  output logic signed [pbw_pkg::OUT_W-1:0]       out_weight_a,
  output logic signed [pbw_pkg::OUT_W-1:0]       out_weight_b,
  output logic signed [pbw_pkg::OUT_W-1:0]       out_weight_c,
  output logic [pbw_pkg::TAG_W-1:0]              out_tag_out,
  output logic                                   out_degenerate,
  input  logic                                   cfg_we,
  input  logic [pbw_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [pbw_pkg::CFG_DATA_W-1:0]         cfg_data
);

  localparam int WSHIFT = pbw_pkg::OUT_W - WEIGHT_FRAC_BITS;
  localparam int SAT3_W = pbw_pkg::DEN3_W + WSHIFT;
  localparam int LAT    = 5 + pbw_pkg::DIV1_K + 1 + pbw_pkg::DIV2_K + 3
                          + pbw_pkg::DIV3_K + 1;

  // ---------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------
  logic [pbw_pkg::XY_W-1:0] vert_xy_r [3];
  logic [pbw_pkg::W_W-1:0]  vert_w_r  [3];
  logic                     busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        vert_xy_r[i] <= '0;
        vert_w_r[i]  <= pbw_pkg::W_RESET;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        pbw_pkg::REG_A_XY: vert_xy_r[0] <= cfg_data;
        pbw_pkg::REG_B_XY: vert_xy_r[1] <= cfg_data;
        pbw_pkg::REG_C_XY: vert_xy_r[2] <= cfg_data;
        pbw_pkg::REG_A_W:  vert_w_r[0]  <= cfg_data[pbw_pkg::W_W-1:0];
        pbw_pkg::REG_B_W:  vert_w_r[1]  <= cfg_data[pbw_pkg::W_W-1:0];
        pbw_pkg::REG_C_W:  vert_w_r[2]  <= cfg_data[pbw_pkg::W_W-1:0];
        default: ;
      endcase
    end
  end

  // busy only during reset and in the cycle straight after it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;

  // ---------------------------------------------------------------
  // stage 1: edge vectors
  // ---------------------------------------------------------------
  logic signed [pbw_pkg::COORD_W-1:0]  vx [3];
  logic signed [pbw_pkg::COORD_W-1:0]  vy [3];
  logic signed [PIXEL_COORD_BITS-1:0]  px_s, py_s;
  logic signed [pbw_pkg::COORD_W-1:0]  px_q, py_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vx[i] = vert_xy_r[i][pbw_pkg::XY_W-1:pbw_pkg::COORD_W];
      vy[i] = vert_xy_r[i][pbw_pkg::COORD_W-1:0];
    end
  end

  assign px_s = in_pixel_x[PIXEL_COORD_BITS-1:0];
  assign py_s = in_pixel_y[PIXEL_COORD_BITS-1:0];
  assign px_q = pbw_pkg::COORD_W'(px_s) <<< pbw_pkg::PIX_FRAC;
  assign py_q = pbw_pkg::COORD_W'(py_s) <<< pbw_pkg::PIX_FRAC;

  logic                               s1_valid_r;
  logic [pbw_pkg::TAG_W-1:0]          s1_tag_r;
  logic signed [pbw_pkg::DIF_W-1:0]   s1_e1x_r, s1_e1y_r, s1_e2x_r, s1_e2y_r;
  logic signed [pbw_pkg::DIF_W-1:0]   s1_epx_r, s1_epy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= start && !busy_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_tag_r <= in_instance_tag;
    s1_e1x_r <= pbw_pkg::DIF_W'(vx[1]) - pbw_pkg::DIF_W'(vx[0]);
    s1_e1y_r <= pbw_pkg::DIF_W'(vy[1]) - pbw_pkg::DIF_W'(vy[0]);
    s1_e2x_r <= pbw_pkg::DIF_W'(vx[2]) - pbw_pkg::DIF_W'(vx[0]);
    s1_e2y_r <= pbw_pkg::DIF_W'(vy[2]) - pbw_pkg::DIF_W'(vy[0]);
    s1_epx_r <= pbw_pkg::DIF_W'(px_q) - pbw_pkg::DIF_W'(vx[0]);
    s1_epy_r <= pbw_pkg::DIF_W'(py_q) - pbw_pkg::DIF_W'(vy[0]);
  end

  // ---------------------------------------------------------------
  // stage 2: cross product terms
  // ---------------------------------------------------------------
  logic                                s2_valid_r;
  logic [pbw_pkg::TAG_W-1:0]           s2_tag_r;
  logic signed [pbw_pkg::PROD_W-1:0]   s2_p_r [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_tag_r  <= s1_tag_r;
    s2_p_r[0] <= s1_e1x_r * s1_e2y_r;
    s2_p_r[1] <= s1_e1y_r * s1_e2x_r;
    s2_p_r[2] <= s1_epx_r * s1_e2y_r;
    s2_p_r[3] <= s1_epy_r * s1_e2x_r;
    s2_p_r[4] <= s1_e1x_r * s1_epy_r;
    s2_p_r[5] <= s1_e1y_r * s1_epx_r;
  end

  // ---------------------------------------------------------------
  // stage 3: determinant and sub-triangle areas of b and c
  // ---------------------------------------------------------------
  logic                               s3_valid_r;
  logic [pbw_pkg::TAG_W-1:0]          s3_tag_r;
  logic signed [pbw_pkg::CRS_W-1:0]   s3_d_r, s3_nb_r, s3_nc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_tag_r <= s2_tag_r;
    s3_d_r   <= pbw_pkg::CRS_W'(s2_p_r[0]) - pbw_pkg::CRS_W'(s2_p_r[1]);
    s3_nb_r  <= pbw_pkg::CRS_W'(s2_p_r[2]) - pbw_pkg::CRS_W'(s2_p_r[3]);
    s3_nc_r  <= pbw_pkg::CRS_W'(s2_p_r[4]) - pbw_pkg::CRS_W'(s2_p_r[5]);
  end

  // ---------------------------------------------------------------
  // stage 4: area of a, degenerate triangle or w check
  // ---------------------------------------------------------------
  logic                              s4_valid_r;
  logic [pbw_pkg::TAG_W-1:0]         s4_tag_r;
  logic                              s4_deg_r;
  logic signed [pbw_pkg::N_W-1:0]    s4_d_r;
  logic signed [pbw_pkg::N_W-1:0]    s4_n_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_tag_r  <= s3_tag_r;
    s4_deg_r  <= (s3_d_r == '0) || (vert_w_r[0] == '0) || (vert_w_r[1] == '0)
                 || (vert_w_r[2] == '0);
    s4_d_r    <= pbw_pkg::N_W'(s3_d_r);
    s4_n_r[0] <= pbw_pkg::N_W'(s3_d_r) - pbw_pkg::N_W'(s3_nb_r)
                 - pbw_pkg::N_W'(s3_nc_r);
    s4_n_r[1] <= pbw_pkg::N_W'(s3_nb_r);
    s4_n_r[2] <= pbw_pkg::N_W'(s3_nc_r);
  end

  // ---------------------------------------------------------------
  // stage 5: magnitudes, signs and saturation for the screen division
  // ---------------------------------------------------------------
  logic [pbw_pkg::N_W-1:0]     d_mag;
  logic [pbw_pkg::N_W-1:0]     n_mag   [3];
  logic                        n_neg   [3];
  logic                        n_sat   [3];

  always_comb begin
    d_mag = s4_d_r[pbw_pkg::N_W-1] ? pbw_pkg::N_W'(-s4_d_r) : pbw_pkg::N_W'(s4_d_r);
    for (int i = 0; i < 3; i++) begin
      n_mag[i] = s4_n_r[i][pbw_pkg::N_W-1] ? pbw_pkg::N_W'(-s4_n_r[i])
                                            : pbw_pkg::N_W'(s4_n_r[i]);
      n_neg[i] = s4_n_r[i][pbw_pkg::N_W-1] ^ s4_d_r[pbw_pkg::N_W-1];
      n_sat[i] = pbw_pkg::SAT1_W'(n_mag[i])
                 >= {d_mag[pbw_pkg::DEN1_W-1:0], {pbw_pkg::SCR_SHIFT{1'b0}}};
    end
  end

  logic                          s5_valid_r;
  pbw_pkg::item_ctl_t            s5_item_r;
  logic [pbw_pkg::DEN1_W-1:0]    s5_den_r;
  logic [pbw_pkg::N_W-1:0]       s5_num_r  [3];
  pbw_pkg::lane_ctl_t            s5_lane_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
    end else begin
      s5_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s5_item_r.deg <= s4_deg_r;
    s5_item_r.tag <= s4_tag_r;
    s5_den_r      <= d_mag[pbw_pkg::DEN1_W-1:0];
    for (int i = 0; i < 3; i++) begin
      s5_num_r[i]      <= n_mag[i];
      s5_lane_r[i].neg <= n_neg[i];
      s5_lane_r[i].sat <= n_sat[i];
    end
  end

  // ---------------------------------------------------------------
  // screen weight dividers: |n| * 2^32 / |d|
  // ---------------------------------------------------------------
  logic                        div1_v    [3];
  logic [pbw_pkg::DIV1_K-1:0]  div1_quot [3];
  pbw_pkg::div_ctl_t           div1_ctl  [3];

  for (genvar i = 0; i < 3; i++) begin : g_div1
    pbw_pkg::div_ctl_t ctl_in;

    assign ctl_in.item = s5_item_r;
    assign ctl_in.lane = s5_lane_r[i];

    pbw_div #(
      .DW  (pbw_pkg::DEN1_W),
      .K   (pbw_pkg::DIV1_K),
      .SBW ($bits(pbw_pkg::div_ctl_t))
    ) u_div1 (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (s5_valid_r),
      .in_rem   (pbw_pkg::DEN1_W'(s5_num_r[i] >> pbw_pkg::SCR_SHIFT)),
      .in_low   ({s5_num_r[i][pbw_pkg::SCR_SHIFT-1:0], {pbw_pkg::SCR_FRAC{1'b0}}}),
      .in_den   (s5_den_r),
      .in_side  (ctl_in),
      .out_valid(div1_v[i]),
      .out_quot (div1_quot[i]),
      .out_side (div1_ctl[i])
    );
  end

  // ---------------------------------------------------------------
  // stage 6: saturated screen weight magnitudes
  // ---------------------------------------------------------------
  logic                        s6_valid_r;
  pbw_pkg::item_ctl_t          s6_item_r;
  logic [pbw_pkg::Q_W-1:0]     s6_smag_r [3];
  logic                        s6_neg_r  [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_valid_r <= 1'b0;
    end else begin
      s6_valid_r <= div1_v[0];
    end
  end

  always_ff @(posedge clk) begin
    s6_item_r <= div1_ctl[0].item;
    for (int i = 0; i < 3; i++) begin
      s6_smag_r[i] <= div1_ctl[i].lane.sat ? pbw_pkg::Q_LIM : div1_quot[i];
      s6_neg_r[i]  <= div1_ctl[i].lane.neg;
    end
  end

  // ---------------------------------------------------------------
  // perspective dividers: s * 2^16 / w
  // ---------------------------------------------------------------
  logic                        div2_v    [3];
  logic [pbw_pkg::DIV2_K-1:0]  div2_quot [3];
  pbw_pkg::div_ctl_t           div2_ctl  [3];

  for (genvar i = 0; i < 3; i++) begin : g_div2
    pbw_pkg::div_ctl_t ctl_in;

    assign ctl_in.item     = s6_item_r;
    assign ctl_in.lane.neg = s6_neg_r[i];
    assign ctl_in.lane.sat = pbw_pkg::SAT2_W'(s6_smag_r[i])
                             >= {vert_w_r[i], {pbw_pkg::W_SAT_SHIFT{1'b0}}};

    pbw_div #(
      .DW  (pbw_pkg::W_W),
      .K   (pbw_pkg::DIV2_K),
      .SBW ($bits(pbw_pkg::div_ctl_t))
    ) u_div2 (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (s6_valid_r),
      .in_rem   (pbw_pkg::W_W'(s6_smag_r[i] >> pbw_pkg::W_SAT_SHIFT)),
      .in_low   ({s6_smag_r[i][pbw_pkg::W_SAT_SHIFT-1:0], {pbw_pkg::W_FRAC{1'b0}}}),
      .in_den   (vert_w_r[i]),
      .in_side  (ctl_in),
      .out_valid(div2_v[i]),
      .out_quot (div2_quot[i]),
      .out_side (div2_ctl[i])
    );
  end

  // ---------------------------------------------------------------
  // stage 7: signed perspective terms
  // ---------------------------------------------------------------
  logic [pbw_pkg::Q_W-1:0]         q_mag [3];
  logic                            s7_valid_r;
  pbw_pkg::item_ctl_t              s7_item_r;
  logic signed [pbw_pkg::Q_SW-1:0] s7_q_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q_mag[i] = div2_ctl[i].lane.sat ? pbw_pkg::Q_LIM : div2_quot[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_valid_r <= 1'b0;
    end else begin
      s7_valid_r <= div2_v[0];
    end
  end

  always_ff @(posedge clk) begin
    s7_item_r <= div2_ctl[0].item;
    for (int i = 0; i < 3; i++) begin
      s7_q_r[i] <= div2_ctl[i].lane.neg ? -pbw_pkg::Q_SW'(q_mag[i])
                                        : pbw_pkg::Q_SW'(q_mag[i]);
    end
  end

  // ---------------------------------------------------------------
  // stage 8: sum of the perspective terms
  // ---------------------------------------------------------------
  logic                             s8_valid_r;
  pbw_pkg::item_ctl_t               s8_item_r;
  logic signed [pbw_pkg::Q_SW-1:0]  s8_q_r [3];
  logic signed [pbw_pkg::SUM_W-1:0] s8_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_valid_r <= 1'b0;
    end else begin
      s8_valid_r <= s7_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s8_item_r <= s7_item_r;
    s8_q_r    <= s7_q_r;
    s8_sum_r  <= pbw_pkg::SUM_W'(s7_q_r[0]) + pbw_pkg::SUM_W'(s7_q_r[1])
                 + pbw_pkg::SUM_W'(s7_q_r[2]);
  end

  // ---------------------------------------------------------------
  // stage 9: normalising division set-up
  // ---------------------------------------------------------------
  logic [pbw_pkg::SUM_W-1:0]  sum_mag;
  logic [pbw_pkg::Q_SW-1:0]   t_mag [3];

  always_comb begin
    sum_mag = s8_sum_r[pbw_pkg::SUM_W-1] ? pbw_pkg::SUM_W'(-s8_sum_r)
                                         : pbw_pkg::SUM_W'(s8_sum_r);
    for (int i = 0; i < 3; i++) begin
      t_mag[i] = s8_q_r[i][pbw_pkg::Q_SW-1] ? pbw_pkg::Q_SW'(-s8_q_r[i])
                                             : pbw_pkg::Q_SW'(s8_q_r[i]);
    end
  end

  logic                         s9_valid_r;
  pbw_pkg::item_ctl_t           s9_item_r;
  logic [pbw_pkg::DEN3_W-1:0]   s9_den_r;
  logic [pbw_pkg::Q_SW-1:0]     s9_num_r  [3];
  pbw_pkg::lane_ctl_t           s9_lane_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s9_valid_r <= 1'b0;
    end else begin
      s9_valid_r <= s8_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s9_item_r.tag <= s8_item_r.tag;
    s9_item_r.deg <= s8_item_r.deg || (s8_sum_r == '0);
    s9_den_r      <= sum_mag[pbw_pkg::DEN3_W-1:0];
    for (int i = 0; i < 3; i++) begin
      s9_num_r[i]      <= t_mag[i];
      s9_lane_r[i].neg <= s8_q_r[i][pbw_pkg::Q_SW-1] ^ s8_sum_r[pbw_pkg::SUM_W-1];
      s9_lane_r[i].sat <= SAT3_W'(t_mag[i])
                          >= {sum_mag[pbw_pkg::DEN3_W-1:0], {WSHIFT{1'b0}}};
    end
  end

  // ---------------------------------------------------------------
  // normalising dividers: |q| * 2^F / |S|
  // ---------------------------------------------------------------
  logic                        div3_v    [3];
  logic [pbw_pkg::DIV3_K-1:0]  div3_quot [3];
  pbw_pkg::div_ctl_t           div3_ctl  [3];

  for (genvar i = 0; i < 3; i++) begin : g_div3
    pbw_pkg::div_ctl_t ctl_in;

    assign ctl_in.item = s9_item_r;
    assign ctl_in.lane = s9_lane_r[i];

    pbw_div #(
      .DW  (pbw_pkg::DEN3_W),
      .K   (pbw_pkg::DIV3_K),
      .SBW ($bits(pbw_pkg::div_ctl_t))
    ) u_div3 (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (s9_valid_r),
      .in_rem   (pbw_pkg::DEN3_W'(s9_num_r[i] >> WSHIFT)),
      .in_low   (pbw_pkg::DIV3_K'(s9_num_r[i] << WEIGHT_FRAC_BITS)),
      .in_den   (s9_den_r),
      .in_side  (ctl_in),
      .out_valid(div3_v[i]),
      .out_quot (div3_quot[i]),
      .out_side (div3_ctl[i])
    );
  end

  // ---------------------------------------------------------------
  // output stage: clamp, sign and degenerate override
  // ---------------------------------------------------------------
  logic [pbw_pkg::OUT_W-1:0] lim   [3];
  logic [pbw_pkg::OUT_W-1:0] w_mag [3];
  logic [pbw_pkg::OUT_W-1:0] w_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lim[i]   = div3_ctl[i].lane.neg ? pbw_pkg::LIM_NEG : pbw_pkg::LIM_POS;
      w_mag[i] = (div3_ctl[i].lane.sat || (div3_quot[i] > lim[i])) ? lim[i]
                                                                   : div3_quot[i];
      if (div3_ctl[0].item.deg) begin
        w_nxt[i] = '0;
      end else if (div3_ctl[i].lane.neg) begin
        w_nxt[i] = -w_mag[i];
      end else begin
        w_nxt[i] = w_mag[i];
      end
    end
  end

  logic                      out_valid_r;
  logic [pbw_pkg::OUT_W-1:0] out_w_r [3];
  logic [pbw_pkg::TAG_W-1:0] out_tag_r;
  logic                      out_deg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= div3_v[0];
    end
  end

  always_ff @(posedge clk) begin
    out_w_r   <= w_nxt;
    out_tag_r <= div3_ctl[0].item.tag;
    out_deg_r <= div3_ctl[0].item.deg;
  end

  assign out_valid      = out_valid_r;
  assign out_weight_a   = out_w_r[0];
  assign out_weight_b   = out_w_r[1];
  assign out_weight_c   = out_w_r[2];
  assign out_tag_out    = out_tag_r;
  assign out_degenerate = out_deg_r;

  // ---------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------
  `PBW_ASSERT_LAT(a_word_emerges, start && !busy, LAT, out_valid,
                  "accepted word did not give a result at the expected latency")
  `PBW_ASSERT_IMP(a_no_spurious_result, out_valid, $past(start && !busy, LAT),
                  "result without a matching accepted word")
  `PBW_ASSERT_IMP(a_degenerate_zero, out_valid && out_degenerate,
                  out_weight_a == '0 && out_weight_b == '0 && out_weight_c == '0,
                  "degenerate result carries nonzero weights")
  `PBW_ASSERT_IMP(a_busy_after_reset_only, $past(rst_n), !busy,
                  "busy raised outside the first cycle after reset")

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Drives pixel words into the barycentric weight pipeline under several
// triangle setups, predicts each result in fixed point (or takes it from a typed row) and checks every field.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;

  localparam int FRAC_BITS  = 28;
  localparam int PIX_BITS   = 16;
  localparam int LATENCY    = 162;
  localparam int CYCLE_CAP  = 600000;
  localparam logic [63:0] MAG_CAP = (64'd1 << 60) - 64'd1;

  typedef struct packed {
    logic [31:0] wa;
    logic [31:0] wb;
    logic [31:0] wc;
    logic [15:0] tag;
    logic        deg;
  } weights_t;

  typedef struct {
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] tag;
    logic        typed;
    weights_t    res;
  } pixel_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] in_pixel_x = '0;
  logic signed [15:0] in_pixel_y = '0;
  logic [pbw_pkg::TAG_W-1:0] in_instance_tag = '0;
  logic out_valid;
  logic signed [pbw_pkg::OUT_W-1:0] out_weight_a, out_weight_b, out_weight_c;
  logic [pbw_pkg::TAG_W-1:0] out_tag_out;
  logic out_degenerate;
  logic cfg_we = 1'b0;
  logic [pbw_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [pbw_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // triangle setup as the predictor sees it
  logic [47:0] tri_xy [3];
  logic [31:0] tri_w [3];

  weights_t pending_weights [$];
  bit failed = 0;
  int unsigned cycles = 0;
  int send_idle_pct = 0;
  pixel_row_t rows [$];

  perspective_barycentric_weights DUT (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [63:0] abs64(logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  // floor(num * 2^fb / den) with early saturation
  function automatic logic [63:0] frac_quot(logic [63:0] num, logic [63:0] den, int fb,
                                            logic [63:0] lim);
    logic [63:0] q, r;
    q = num / den;
    r = num % den;
    if (q > lim) return lim;
    for (int i = 0; i < fb; i++) begin
      q = q << 1;
      r = r << 1;
      if (r >= den) begin
        r = r - den;
        q = q + 1;
      end
      if (q > lim) return lim;
    end
    return q;
  endfunction

  function automatic logic signed [63:0] signed_quot(logic signed [63:0] num,
      logic signed [63:0] den, int fb, logic [63:0] plim, logic [63:0] nlim);
    bit neg;
    logic [63:0] m;
    neg = (num < 0) != (den < 0);
    m = frac_quot(abs64(num), abs64(den), fb, neg ? nlim : plim);
    return neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic weights_t predict_weights(logic [15:0] px16, logic [15:0] py16,
                                               logic [15:0] tag);
    logic signed [63:0] vx [3], vy [3], nw [3], qw [3];
    logic signed [63:0] px, py, eax, eay, ebx, eby, ecx, ecy, det, sum, sc;
    weights_t r;
    for (int i = 0; i < 3; i++) begin
      vx[i] = 64'($signed(tri_xy[i][47:24]));
      vy[i] = 64'($signed(tri_xy[i][23:0]));
    end
    px = 64'($signed(px16[PIX_BITS-1:0])) * 256;
    py = 64'($signed(py16[PIX_BITS-1:0])) * 256;
    eax = vx[1] - vx[0]; eay = vy[1] - vy[0];
    ebx = vx[2] - vx[0]; eby = vy[2] - vy[0];
    ecx = px - vx[0];    ecy = py - vy[0];
    det = eax * eby - eay * ebx;
    nw[1] = ecx * eby - ecy * ebx;
    nw[2] = eax * ecy - eay * ecx;
    nw[0] = det - nw[1] - nw[2];
    r = '0;
    r.tag = tag;
    if (det == 0 || tri_w[0] == 0 || tri_w[1] == 0 || tri_w[2] == 0) begin
      r.deg = 1'b1;
      return r;
    end
    for (int i = 0; i < 3; i++) begin
      sc = signed_quot(nw[i], det, 32, MAG_CAP, MAG_CAP);
      qw[i] = signed_quot(sc, $signed({32'd0, tri_w[i]}), 16, MAG_CAP, MAG_CAP);
    end
    sum = qw[0] + qw[1] + qw[2];
    if (sum == 0) begin
      r.deg = 1'b1;
      return r;
    end
    r.wa = 32'(signed_quot(qw[0], sum, FRAC_BITS, 64'h7FFF_FFFF, 64'h8000_0000));
    r.wb = 32'(signed_quot(qw[1], sum, FRAC_BITS, 64'h7FFF_FFFF, 64'h8000_0000));
    r.wc = 32'(signed_quot(qw[2], sum, FRAC_BITS, 64'h7FFF_FFFF, 64'h8000_0000));
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    weights_t got, want;
    if (rst_n && out_valid) begin
      got = '{out_weight_a, out_weight_b, out_weight_c, out_tag_out, out_degenerate};
      if (pending_weights.size() == 0) begin
        $display("%0t unexpected word: got %h", $time, got);
        failed = 1;
      end else begin
        want = pending_weights.pop_front();
        if (got.wa !== want.wa)
          $display("%0t weight_a: expected %h got %h", $time, want.wa, got.wa);
        if (got.wb !== want.wb)
          $display("%0t weight_b: expected %h got %h", $time, want.wb, got.wb);
        if (got.wc !== want.wc)
          $display("%0t weight_c: expected %h got %h", $time, want.wc, got.wc);
        if (got.tag !== want.tag)
          $display("%0t tag_out: expected %h got %h", $time, want.tag, got.tag);
        if (got.deg !== want.deg)
          $display("%0t degenerate: expected %b got %b", $time, want.deg, got.deg);
        if (got !== want) failed = 1;
      end
    end
  end

  task automatic write_reg(pbw_pkg::cfg_reg_t idx, logic [47:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      pbw_pkg::REG_A_XY: tri_xy[0] = val;
      pbw_pkg::REG_B_XY: tri_xy[1] = val;
      pbw_pkg::REG_C_XY: tri_xy[2] = val;
      pbw_pkg::REG_A_W:  tri_w[0] = val[31:0];
      pbw_pkg::REG_B_W:  tri_w[1] = val[31:0];
      pbw_pkg::REG_C_W:  tri_w[2] = val[31:0];
      default: ;
    endcase
  endtask

  function automatic logic [47:0] pack_xy(int x, int y);
    return {24'(x), 24'(y)};
  endfunction

  task automatic load_triangle(logic [47:0] a, logic [47:0] b, logic [47:0] c,
                               logic [31:0] wa, logic [31:0] wb, logic [31:0] wc);
    write_reg(pbw_pkg::REG_A_XY, a);
    write_reg(pbw_pkg::REG_B_XY, b);
    write_reg(pbw_pkg::REG_C_XY, c);
    write_reg(pbw_pkg::REG_A_W, {16'd0, wa});
    write_reg(pbw_pkg::REG_B_W, {16'd0, wb});
    write_reg(pbw_pkg::REG_C_W, {16'd0, wc});
  endtask

  // append one row to the stimulus table
  task automatic add_row(logic [15:0] px, logic [15:0] py, logic [15:0] tag,
                         bit typed, weights_t res);
    pixel_row_t row;
    row = '{px, py, tag, typed, res};
    rows = {rows, row};
  endtask

  // one pixel word, taken when busy is low; start held across back-to-back words
  task automatic send_pixel(logic [15:0] px, logic [15:0] py, logic [15:0] tag,
                            bit typed, weights_t res);
    weights_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_pixel_x <= px;
    in_pixel_y <= py;
    in_instance_tag <= tag;
    @(posedge clk);
    while (busy) @(posedge clk);
    want = typed ? res : predict_weights(px, py, tag);
    pending_weights = {pending_weights, want};
    @(negedge clk);
  endtask

  // called at a falling edge: drop start at once so the last word is not taken twice
  task automatic drain();
    start <= 1'b0;
    while (pending_weights.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(64)) - 16'd32;
      default: return 16'($urandom_range(400));
    endcase
  endfunction

  task automatic random_setup();
    int span;
    span = $urandom_range(3) == 0 ? 24'h7FFFFF : 24'h01FFFF;
    load_triangle(pack_xy($urandom_range(span) - span / 2, $urandom_range(span) - span / 2),
                  pack_xy($urandom_range(span) - span / 2, $urandom_range(span) - span / 2),
                  pack_xy($urandom_range(span) - span / 2, $urandom_range(span) - span / 2),
                  $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h40000, 1),
                  $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h40000, 1),
                  $urandom_range(7) == 0 ? 32'd0 : $urandom_range(32'h40000, 1));
  endtask

  initial begin
    weights_t zero_deg;
    tri_xy = '{default: '0};
    tri_w = '{default: pbw_pkg::W_RESET};
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // after reset every vertex sits at the origin: degenerate with zero weights
    zero_deg = '0;
    zero_deg.deg = 1'b1;
    add_row(16'h7FFF, 16'h8000, 16'hFFFF, 1'b1, '{0, 0, 0, 16'hFFFF, 1'b1});
    add_row(16'h0000, 16'h0000, 16'h0000, 1'b1, zero_deg);
    foreach (rows[i]) send_pixel(rows[i].px, rows[i].py, rows[i].tag, rows[i].typed,
                                 rows[i].res);
    drain();

    // right triangle of unit w; vertices, centre, extremes of the pixel range
    load_triangle(pack_xy(0, 0), pack_xy(100 * 256, 0), pack_xy(0, 100 * 256),
                  32'h10000, 32'h10000, 32'h10000);
    rows.delete();
    add_row(16'd0, 16'd0, 16'h1234, 1'b1, '{32'h1000_0000, 0, 0, 16'h1234, 0});
    add_row(16'd100, 16'd0, 16'h0001, 1'b1, '{0, 32'h1000_0000, 0, 16'h0001, 0});
    add_row(16'd0, 16'd100, 16'h8000, 1'b1, '{0, 0, 32'h1000_0000, 16'h8000, 0});
    add_row(16'd33, 16'd33, 16'h5555, 1'b0, '0);
    add_row(16'h7FFF, 16'h7FFF, 16'hAAAA, 1'b0, '0);
    add_row(16'h8000, 16'h8000, 16'hFFFF, 1'b0, '0);
    add_row(16'h8000, 16'h7FFF, 16'h0F0F, 1'b0, '0);
    add_row(16'd100, 16'd100, 16'hF0F0, 1'b0, '0);
    foreach (rows[i]) send_pixel(rows[i].px, rows[i].py, rows[i].tag, rows[i].typed,
                                 rows[i].res);
    drain();

    // extreme positions and w values, then a zero w
    load_triangle(48'h800000_800000, 48'h7FFFFF_800000, 48'h800000_7FFFFF,
                  32'hFFFF_FFFF, 32'd1, 32'h8000_0000);
    send_pixel(16'h8000, 16'h8000, 16'h0002, 1'b0, '0);
    send_pixel(16'h7FFF, 16'h0000, 16'h0003, 1'b0, '0);
    send_pixel(16'h1234, 16'hEDCB, 16'h0004, 1'b0, '0);
    drain();
    write_reg(pbw_pkg::REG_B_W, 48'hFFFF_0000_0000);
    send_pixel(16'd5, 16'd5, 16'h0005, 1'b0, '0);
    drain();
    // pixel (1, -1), where the b and c weights cancel, then vertex b itself
    load_triangle(pack_xy(0, 0), pack_xy(256, 0), pack_xy(0, 256),
                  32'h10000, 32'h10000, 32'h10000);
    send_pixel(16'd1, 16'hFFFF, 16'h0006, 1'b0, '0);
    send_pixel(16'd1, 16'd0, 16'h0007, 1'b0, '0);
    drain();
    // index past the last register changes nothing
    write_reg(pbw_pkg::cfg_reg_t'(3'd7), 48'hFFFF_FFFF_FFFF);
    send_pixel(16'd0, 16'd1, 16'h0008, 1'b0, '0);
    drain();

    // random phases: sender idles, then not
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = phase == 0 ? 33 : (phase == 1 ? 84 : 0);
      for (int s = 0; s < 7; s++) begin
        random_setup();
        for (int k = 0; k < 50; k++) begin
          if ($urandom_range(3) == 0)
            send_pixel(16'($urandom), 16'($urandom), 16'($urandom), 1'b0, '0);
          else
            send_pixel(rand_coord(), rand_coord(), 16'($urandom), 1'b0, '0);
        end
        drain();
      end
    end

    repeat (LATENCY + 20) @(negedge clk);
    if (!failed && pending_weights.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
